// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/clsr_pkg.sv =====
`timescale 1ns / 1ps

package clsr_pkg;

    localparam int TABLE_SIZE_DEF = 32;

    localparam logic [30:0] MOD_ONE  = 31'd2147483563;
    localparam logic [30:0] MOD_TWO  = 31'd2147483399;
    localparam logic [30:0] OUT_MAX  = 31'd2147483562;
    localparam logic [30:0] TWO_INIT = 31'd123456789;
    localparam logic [15:0] MUL_ONE  = 16'd40014;
    localparam logic [15:0] MUL_TWO  = 16'd40692;
    localparam logic [7:0]  FOLD_ONE = 8'd85;
    localparam logic [7:0]  FOLD_TWO = 8'd249;

    localparam int RECIP_SHIFT = 37;

    typedef struct packed {
        logic load_seed;
        logic seed_one;
        logic mul_en;
        logic red_one;
        logic red_two;
        logic slot_en;
        logic rd_en;
        logic warm_wr;
        logic warm_last;
        logic fin;
    } dp_cmd_t;

    // The modulus is 2^31 - c, so a product folds as hi * c + lo.
    function automatic logic [30:0] mod_fold(input logic [46:0] p, input logic [7:0] c,
                                             input logic [30:0] m);
        logic [23:0] h;
        logic [31:0] s1;
        logic [31:0] s2;
        h  = {8'd0, p[46:31]} * {16'd0, c};
        s1 = {1'b0, p[30:0]} + {8'd0, h};
        s2 = {1'b0, s1[30:0]} + (s1[31] ? {24'd0, c} : 32'd0);
        if (s2 >= {1'b0, m})
        begin
            s2 = s2 - {1'b0, m};
        end
        return s2[30:0];
    endfunction

endpackage

// ===== design/clsr_ctrl.sv =====
`timescale 1ns / 1ps

module clsr_ctrl #(
    parameter int TABLE_SIZE = clsr_pkg::TABLE_SIZE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic                          cmd,
    output logic                          deviate_valid,
    input  logic                          deviate_ready,
    output clsr_pkg::dp_cmd_t             dp_cmd,
    output logic [$clog2(TABLE_SIZE)-1:0] warm_idx
);
    import clsr_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);
    localparam int CW = $clog2(TABLE_SIZE + 8);

    typedef enum logic [2:0] {
        S_IDLE,
        S_W_MUL,
        S_W_RED,
        S_D_MUL,
        S_D_RED,
        S_D_READ,
        S_D_FIN
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          seeded_reg, seeded_next;
    logic          out_valid_reg, out_valid_next;

    assign item_ready    = (state_reg == S_IDLE);
    assign deviate_valid = out_valid_reg;
    assign warm_idx      = cnt_reg[IW-1:0];

    always_comb
    begin
        dp_cmd         = '0;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        seeded_next    = seeded_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && deviate_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (!cmd || !seeded_reg)
                    begin
                        dp_cmd.load_seed = 1'b1;
                        dp_cmd.seed_one  = cmd;
                        seeded_next      = 1'b1;
                        cnt_next         = CW'(TABLE_SIZE + 7);
                        state_next       = S_W_MUL;
                    end
                    else
                    begin
                        state_next = S_D_MUL;
                    end
                end
            end
            S_W_MUL:
            begin
                dp_cmd.mul_en = 1'b1;
                state_next    = S_W_RED;
            end
            S_W_RED:
            begin
                dp_cmd.red_one = 1'b1;
                dp_cmd.warm_wr = (cnt_reg < CW'(TABLE_SIZE));
                if (cnt_reg == '0)
                begin
                    dp_cmd.warm_last = 1'b1;
                    state_next       = S_D_MUL;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_W_MUL;
                end
            end
            S_D_MUL:
            begin
                dp_cmd.mul_en = 1'b1;
                state_next    = S_D_RED;
            end
            S_D_RED:
            begin
                dp_cmd.red_one = 1'b1;
                dp_cmd.red_two = 1'b1;
                dp_cmd.slot_en = 1'b1;
                state_next     = S_D_READ;
            end
            S_D_READ:
            begin
                dp_cmd.rd_en = 1'b1;
                state_next   = S_D_FIN;
            end
            S_D_FIN:
            begin
                if (!out_valid_reg || deviate_ready)
                begin
                    dp_cmd.fin     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            seeded_reg    <= seeded_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/clsr_dp.sv =====
`timescale 1ns / 1ps

module clsr_dp #(
    parameter int TABLE_SIZE = clsr_pkg::TABLE_SIZE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  clsr_pkg::dp_cmd_t             dp_cmd,
    input  logic [$clog2(TABLE_SIZE)-1:0] warm_idx,
    input  logic [30:0]                   seed_value,
    output logic [30:0]                   deviate
);
    import clsr_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);
    localparam int QW = $clog2(TABLE_SIZE) + 1;
    localparam longint unsigned SLOT_DIV = 64'd1 + 64'(OUT_MAX) / 64'(TABLE_SIZE);
    localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / SLOT_DIV;
    localparam int RW = $clog2(RECIP + 1);
    localparam int PW = 31 + RW;

    logic [30:0]        mem [TABLE_SIZE];
    logic [30:0]        gen_one_reg, gen_one_next;
    logic [30:0]        gen_two_reg, gen_two_next;
    logic [30:0]        last_out_reg, last_out_next;
    logic [46:0]        prod_one_reg;
    logic [46:0]        prod_two_reg;
    logic [QW-1:0]      est_reg;
    logic [IW-1:0]      slot_reg;
    logic [30:0]        rd_reg;
    logic [30:0]        deviate_reg;

    logic [30:0]        red_one;
    logic [30:0]        red_two;
    logic [30:0]        seed_fix;
    logic [PW-1:0]      est_prod;
    logic [QW+30:0]     est_d;
    logic [QW+30:0]     rem;
    logic [QW-1:0]      q_fix;
    logic [IW-1:0]      slot_next;
    logic signed [32:0] mix;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic [30:0]        wr_data;

    assign deviate  = deviate_reg;
    assign red_one  = mod_fold(prod_one_reg, FOLD_ONE, MOD_ONE);
    assign red_two  = mod_fold(prod_two_reg, FOLD_TWO, MOD_TWO);
    assign seed_fix = (dp_cmd.seed_one || seed_value == '0) ? 31'd1 : seed_value;
    assign est_prod = {{RW{1'b0}}, last_out_reg} * {{31{1'b0}}, RW'(RECIP)};
    assign est_d    = {{31{1'b0}}, est_reg} * {{QW{1'b0}}, 31'(SLOT_DIV)};
    assign rem      = {{QW{1'b0}}, last_out_reg} - est_d;
    assign wr_en    = dp_cmd.warm_wr || dp_cmd.fin;
    assign wr_addr  = dp_cmd.fin ? slot_reg : warm_idx;
    assign wr_data  = dp_cmd.fin ? gen_one_reg : red_one;

    always_comb
    begin
        q_fix = est_reg + ((rem >= (QW + 31)'(SLOT_DIV)) ? QW'(1) : QW'(0));
        if (q_fix >= QW'(TABLE_SIZE))
        begin
            slot_next = IW'(TABLE_SIZE - 1);
        end
        else
        begin
            slot_next = q_fix[IW-1:0];
        end
        mix = $signed({2'b00, rd_reg}) - $signed({2'b00, gen_two_reg});
        if (mix < 33'sd1)
        begin
            mix = mix + $signed({2'b00, OUT_MAX});
        end
    end

    always_comb
    begin
        gen_one_next  = gen_one_reg;
        gen_two_next  = gen_two_reg;
        last_out_next = last_out_reg;
        if (dp_cmd.load_seed)
        begin
            gen_one_next = seed_fix;
            gen_two_next = seed_fix;
        end
        if (dp_cmd.red_one)
        begin
            gen_one_next = red_one;
        end
        if (dp_cmd.red_two)
        begin
            gen_two_next = red_two;
        end
        if (dp_cmd.warm_last)
        begin
            last_out_next = red_one;
        end
        if (dp_cmd.fin)
        begin
            last_out_next = mix[30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_one_reg  <= 31'd1;
            gen_two_reg  <= TWO_INIT;
            last_out_reg <= '0;
        end
        else
        begin
            gen_one_reg  <= gen_one_next;
            gen_two_reg  <= gen_two_next;
            last_out_reg <= last_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.mul_en)
        begin
            prod_one_reg <= {16'd0, gen_one_reg} * {31'd0, MUL_ONE};
            prod_two_reg <= {16'd0, gen_two_reg} * {31'd0, MUL_TWO};
            est_reg      <= QW'(est_prod >> RECIP_SHIFT);
        end
        if (dp_cmd.slot_en)
        begin
            slot_reg <= slot_next;
        end
        if (dp_cmd.fin)
        begin
            deviate_reg <= mix[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (dp_cmd.rd_en)
        begin
            rd_reg <= mem[slot_reg];
        end
    end

endmodule

// ===== design/combined_lcg_shuffle_rng.sv =====
`timescale 1ns / 1ps

// Channel  | Handshake                      | Payload
// ---------+--------------------------------+--------------------------
// item     | item_valid / item_ready        | cmd, seed_value
// deviate  | deviate_valid / deviate_ready  | deviate
//
// A draw beat runs from acceptance through the multiply, reduce, table read and
// mix steps of the datapath; the mix step waits while the output is still stalled.
// A reseed beat first runs TABLE_SIZE + 8 warm-up steps, each a multiply and a
// reduce step, and then goes through the same steps as a draw.
// Reset is asynchronous and active low; the shuffle table needs no clearing.
// One beat is worked on at a time; a finished deviate waits in the output register.
module combined_lcg_shuffle_rng #(
    parameter int TABLE_SIZE = clsr_pkg::TABLE_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        cmd,
    input  logic [30:0] seed_value,
    output logic        deviate_valid,
    input  logic        deviate_ready,
    output logic [30:0] deviate
);
    import clsr_pkg::*;

    dp_cmd_t                       dp_cmd;
    logic [$clog2(TABLE_SIZE)-1:0] warm_idx;

    clsr_ctrl #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .cmd          (cmd),
        .deviate_valid(deviate_valid),
        .deviate_ready(deviate_ready),
        .dp_cmd       (dp_cmd),
        .warm_idx     (warm_idx)
    );

    clsr_dp #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_cmd    (dp_cmd),
        .warm_idx  (warm_idx),
        .seed_value(seed_value),
        .deviate   (deviate)
    );

endmodule

// ===== design/clsr_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clsr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_ready,
    input logic        deviate_valid,
    input logic        deviate_ready,
    input logic [30:0] deviate
);

    `ASSERT_CLK(a_out_hold, clk, rst_n,
        deviate_valid && !deviate_ready |=> deviate_valid,
        "deviate beat dropped while stalled")
    `ASSERT_CLK(a_out_stable, clk, rst_n,
        deviate_valid && !deviate_ready |=> $stable(deviate),
        "deviate changed while stalled")
    `ASSERT_CLK(a_out_range, clk, rst_n,
        deviate_valid |-> deviate >= 31'd1 && deviate <= 31'd2147483562,
        "deviate out of range")
    `ASSERT_CLK(a_one_at_a_time, clk, rst_n,
        item_valid && item_ready |=> !item_ready,
        "item taken while one is in work")
    `ASSERT_CLK_ALWAYS(a_reset_quiet, clk,
        !rst_n |=> !deviate_valid,
        "deviate valid during reset")

endmodule

bind combined_lcg_shuffle_rng clsr_checker u_clsr_checker (.*);

// ===== tb/combined_lcg_shuffle_rng_tb.sv =====
`timescale 1ns / 1ps

module combined_lcg_shuffle_rng_tb;

    import clsr_pkg::*;

    localparam int TS = TABLE_SIZE_DEF;
    localparam logic CMD_RESEED = 1'b0;
    localparam logic CMD_DRAW = 1'b1;
    localparam logic [30:0] SLOT_DIV = 31'(1 + OUT_MAX / TS);
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = TS + 45;
    localparam int RANDOM_ITEMS = 700;

    typedef struct packed {
        logic        op;
        logic [30:0] seed;
    } rng_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic        cmd = CMD_DRAW;
    logic [30:0] seed_value = 31'd0;
    logic        deviate_valid;
    logic        deviate_ready = 1'b0;
    logic [30:0] deviate;

    rng_item_t   pending_items[$];
    logic [30:0] expected_deviates[$];

    logic [30:0] lcg_one;
    logic [30:0] lcg_two;
    logic [30:0] prev_deviate;
    logic [30:0] shuffle[TS];
    logic        primed;

    int          mismatches = 0;
    int          items_sent = 0;
    int          deviates_seen = 0;
    int          send_gap = 0;
    int          recv_stall = 0;
    int          idle_cycles = 0;
    logic        next_valid;
    logic [30:0] wanted;

    combined_lcg_shuffle_rng uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .cmd          (cmd),
        .seed_value   (seed_value),
        .deviate_valid(deviate_valid),
        .deviate_ready(deviate_ready),
        .deviate      (deviate)
    );

    always #5 clk = ~clk;

    function automatic logic [30:0] mod_mult(input logic [30:0] z, input logic [15:0] a,
                                             input logic [30:0] m);
        logic [63:0] p;
        p = 64'(z) * 64'(a);
        return 31'(p % 64'(m));
    endfunction

    task automatic load_table(input logic [30:0] seed);
        logic [30:0] s;
        s = (seed == 31'd0) ? 31'd1 : seed;
        lcg_one = s;
        lcg_two = s;
        for (int n = TS + 7; n >= 0; n--)
        begin
            lcg_one = mod_mult(lcg_one, MUL_ONE, MOD_ONE);
            if (n < TS)
            begin
                shuffle[n] = lcg_one;
            end
        end
        prev_deviate = shuffle[0];
        primed = 1'b1;
    endtask

    task automatic next_deviate(output logic [30:0] dev);
        logic [30:0] slot;
        longint      mix;
        lcg_one = mod_mult(lcg_one, MUL_ONE, MOD_ONE);
        lcg_two = mod_mult(lcg_two, MUL_TWO, MOD_TWO);
        slot = prev_deviate / SLOT_DIV;
        if (slot >= 31'(TS))
        begin
            slot = 31'(TS - 1);
        end
        mix = longint'(shuffle[slot]) - longint'(lcg_two);
        shuffle[slot] = lcg_one;
        if (mix < 1)
        begin
            mix = mix + longint'(OUT_MAX);
        end
        prev_deviate = mix[30:0];
        dev = prev_deviate;
    endtask

    task automatic predict_item(input logic op, input logic [30:0] seed);
        logic [30:0] dev;
        if (op == CMD_RESEED)
        begin
            load_table(seed);
        end
        else if (!primed)
        begin
            load_table(31'd1);
        end
        next_deviate(dev);
        expected_deviates.push_back(dev);
    endtask

    task automatic report_mismatch(input string what, input logic [30:0] want,
                                   input logic [30:0] got);
        $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
        mismatches++;
    endtask

    function automatic int pick_delay(input int count);
        int r;
        if ((count / 60) % 4 == 3)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [30:0] pick_seed();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 31'd0;
            1: return OUT_MAX - 31'($urandom_range(0, 3));
            2: return 31'h7FFFFFFF - 31'($urandom_range(0, 300));
            3: return 31'($urandom_range(1, 4));
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic queue_item(input logic op, input logic [30:0] seed);
        rng_item_t it;
        it.op = op;
        it.seed = seed;
        pending_items.push_back(it);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            next_valid = item_valid;
            if (item_valid && item_ready)
            begin
                predict_item(cmd, seed_value);
                items_sent++;
                next_valid = 1'b0;
                send_gap = pick_delay(items_sent);
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (pending_items.size() > 0)
                begin
                    cmd <= pending_items[0].op;
                    seed_value <= pending_items[0].seed;
                    void'(pending_items.pop_front());
                    next_valid = 1'b1;
                end
            end
            item_valid <= next_valid;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (deviate_valid && deviate_ready)
            begin
                deviates_seen++;
                if (expected_deviates.size() == 0)
                begin
                    report_mismatch("unexpected deviate", 31'd0, deviate);
                end
                else
                begin
                    wanted = expected_deviates.pop_front();
                    if (deviate !== wanted)
                    begin
                        report_mismatch("deviate", wanted, deviate);
                    end
                end
                recv_stall = pick_delay(deviates_seen);
            end
            else if (deviate_ready && recv_stall == 0 && $urandom_range(0, 15) == 0)
            begin
                recv_stall = pick_delay(deviates_seen);
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                deviate_ready <= 1'b0;
            end
            else
            begin
                deviate_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (deviate_valid && deviate_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("combined_lcg_shuffle_rng verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        primed = 1'b0;
        lcg_one = 31'd1;
        lcg_two = TWO_INIT;
        prev_deviate = 31'd0;

        // A draw before any seed behaves as seed one.
        queue_item(CMD_DRAW, 31'h7FFFFFFF);
        queue_item(CMD_DRAW, 31'd0);
        queue_item(CMD_RESEED, 31'd0);
        queue_item(CMD_DRAW, 31'd5);
        queue_item(CMD_DRAW, 31'd0);
        queue_item(CMD_RESEED, 31'd1);
        queue_item(CMD_DRAW, 31'h55555555);
        queue_item(CMD_RESEED, OUT_MAX);
        queue_item(CMD_DRAW, 31'd0);
        queue_item(CMD_RESEED, 31'h7FFFFFFF);
        queue_item(CMD_DRAW, 31'd0);
        // A seed equal to a modulus pins that generator at zero.
        queue_item(CMD_RESEED, MOD_ONE);
        queue_item(CMD_DRAW, 31'd0);
        queue_item(CMD_DRAW, 31'd0);
        queue_item(CMD_DRAW, 31'd0);
        queue_item(CMD_RESEED, MOD_TWO);
        queue_item(CMD_DRAW, 31'd0);
        queue_item(CMD_DRAW, 31'd0);
        queue_item(CMD_RESEED, 31'h2AAAAAAA);
        queue_item(CMD_DRAW, 31'h2AAAAAAA);
        queue_item(CMD_RESEED, 31'h55555555);
        queue_item(CMD_DRAW, 31'h7FFFFFFF);
        queue_item(CMD_DRAW, 31'd0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 99) < 10)
            begin
                queue_item(CMD_RESEED, pick_seed());
            end
            else
            begin
                queue_item(CMD_DRAW, 31'($urandom));
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() > 0 || item_valid || expected_deviates.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_deviates.size() == 0)
        begin
            $display("combined_lcg_shuffle_rng verification clean");
        end
        else
        begin
            $display("combined_lcg_shuffle_rng verification failed");
        end
        $finish;
    end

endmodule
